@@ rtl/file_name_hash_assert.svh @@
// ----------------------------------------------------------------------------
// file_name_hash assertion macros
// Shorthand for clocked implications used by the port checker.
// ----------------------------------------------------------------------------
`ifndef FILE_NAME_HASH_ASSERT_SVH
`define FILE_NAME_HASH_ASSERT_SVH

// same-cycle implication, disabled while rst is high
`define FNH_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("file_name_hash: same-cycle check failed");

// next-cycle implication, disabled while rst is high
`define FNH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("file_name_hash: next-cycle check failed");

// next-cycle implication that is also checked during reset
`define FNH_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("file_name_hash: reset check failed");

`endif

@@ rtl/fnh_pkg.sv @@
// ----------------------------------------------------------------------------
// fnh_pkg
// Shared types and constants of the file name hash block.
// ----------------------------------------------------------------------------
package fnh_pkg;

   // hash constants
   localparam logic [31:0] HASH_MODULUS   = 32'h8000_000b;
   localparam logic [31:0] HASH_FINAL_XOR = 32'h1234_5678;

   // character codes
   localparam logic [7:0] CASE_OFFSET    = 8'h20;
   localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z   = 8'h5a;
   localparam logic [7:0] CHAR_SLASH     = 8'h2f;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;

   // fold modes
   localparam logic [1:0] FOLD_RAW  = 2'd0;
   localparam logic [1:0] FOLD_CASE = 2'd1;
   localparam logic [1:0] FOLD_PATH = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_FOLD_MODE   = 2'd0;
   localparam logic [1:0] CSR_CHAR_SIGNED = 2'd1;

   // classified word passed from front to back
   typedef struct packed {
      logic [8:0] value;     // byte, sign- or zero-extended to 9 bits
      logic       has_byte;  // byte takes part in the hash
      logic       is_last;   // end of name, emit result
   } cmd_type;

   typedef enum logic {
      BK_IDLE,
      BK_FOLD
   } bk_state_type;

endpackage

@@ rtl/fnh_fifo.sv @@
// ----------------------------------------------------------------------------
// fnh_fifo
// Small flop-based queue with full and empty flags.
// ----------------------------------------------------------------------------
module fnh_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

@@ rtl/fnh_front.sv @@
// ----------------------------------------------------------------------------
// fnh_front
// Control registers and byte classification: fold, sign, zero-byte check.
// ----------------------------------------------------------------------------
module fnh_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_wdata,
   input  logic [7:0]       name_byte,
   input  logic             has_byte,
   input  logic             is_last,
   output fnh_pkg::cmd_type cmd
);

   import fnh_pkg::*;

   logic [1:0] fold_mode_ff, fold_mode_in;
   logic       char_signed_ff, char_signed_in;
   logic [7:0] folded;
   logic       is_upper;

   always_comb begin
      fold_mode_in   = fold_mode_ff;
      char_signed_in = char_signed_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FOLD_MODE:   fold_mode_in   = csr_wdata[1:0];
            CSR_CHAR_SIGNED: char_signed_in = csr_wdata[0];
            default: ;  // no register here
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_mode_ff   <= FOLD_RAW;
         char_signed_ff <= 1'b1;
      end else begin
         fold_mode_ff   <= fold_mode_in;
         char_signed_ff <= char_signed_in;
      end
   end

   assign is_upper = (name_byte >= CHAR_UPPER_A) && (name_byte <= CHAR_UPPER_Z);

   always_comb begin
      folded = name_byte;
      case (fold_mode_ff)
         FOLD_RAW: ;
         FOLD_CASE: begin
            if (is_upper) folded = name_byte + CASE_OFFSET;
         end
         default: begin  // path fold; mode three behaves the same
            if (is_upper) begin
               folded = name_byte + CASE_OFFSET;
            end else if (name_byte == CHAR_SLASH) begin
               folded = CHAR_BACKSLASH;
            end
         end
      endcase
   end

   always_comb begin
      cmd.value    = {char_signed_ff & folded[7], folded};
      cmd.has_byte = has_byte & (name_byte != '0);  // NUL hashes nothing
      cmd.is_last  = is_last;
   end

endmodule

@@ rtl/fnh_back.sv @@
// ----------------------------------------------------------------------------
// fnh_back
// Hash engine: mix the weighted byte in, then reduce and scale.
// ----------------------------------------------------------------------------
module fnh_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_empty,
   input  fnh_pkg::cmd_type cmd,
   output logic             cmd_pop,
   input  logic             rsp_full,
   output logic             rsp_push,
   output logic [31:0]      rsp_hash
);

   import fnh_pkg::*;

   bk_state_type state_ff, state_in;

   logic [31:0] hash_ff, hash_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] sum_ff, sum_in;
   logic        has_ff, has_in;
   logic        last_ff, last_in;

   logic [31:0] weight, value_ext, product;
   logic [31:0] reduced, scaled, hash_next;
   logic        advance;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: if (!cmd_empty) state_in = BK_FOLD;
         BK_FOLD: if (advance)    state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd_pop  = 1'b0;
      advance  = 1'b0;
      rsp_push = 1'b0;
      unique case (state_ff)
         BK_IDLE: cmd_pop = ~cmd_empty;
         BK_FOLD: begin
            advance  = ~last_ff | ~rsp_full;
            rsp_push = last_ff & ~rsp_full;
         end
         default: ;
      endcase
   end

   // first half: running hash plus (pos+1) * byte
   assign weight    = pos_ff + 32'd1;
   assign value_ext = {{23{cmd.value[8]}}, cmd.value};
   assign product   = weight * value_ext;

   // second half: mod by one compare-subtract (sum < 2*modulus), times -17
   assign reduced   = (sum_ff >= HASH_MODULUS) ? sum_ff - HASH_MODULUS : sum_ff;
   assign scaled    = 32'd0 - ((reduced << 4) + reduced);
   assign hash_next = has_ff ? scaled : hash_ff;
   assign rsp_hash  = hash_next ^ HASH_FINAL_XOR;

   always_comb begin
      sum_in  = sum_ff;
      has_in  = has_ff;
      last_in = last_ff;
      hash_in = hash_ff;
      pos_in  = pos_ff;
      if (cmd_pop) begin
         sum_in  = hash_ff + product;
         has_in  = cmd.has_byte;
         last_in = cmd.is_last;
      end
      if (advance) begin
         if (last_ff) begin
            hash_in = '0;
            pos_in  = '0;
         end else if (has_ff) begin
            hash_in = scaled;
            pos_in  = pos_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         hash_ff  <= '0;
         pos_ff   <= '0;
         has_ff   <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         hash_ff  <= hash_in;
         pos_ff   <= pos_in;
         has_ff   <= has_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

endmodule

@@ rtl/file_name_hash.sv @@
// ----------------------------------------------------------------------------
// file_name_hash
// Streaming 32-bit hash of a name, one byte per word, result on the last word.
//
//   channel  direction  handshake            payload
//   req      in         req_push / req_full  req_name_byte, req_has_byte, req_is_last
//   rsp      out        rsp_pop / rsp_empty  rsp_hash_value
//   csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// Each word goes through the engine states in turn: BK_IDLE adds (pos+1)*byte to the
// running hash, BK_FOLD does the modulo and the scale by -17; this loop sets rate, as
// no new word is taken before BK_FOLD ends. A last word passes BK_IDLE, BK_FOLD, then rsp_q.
// Reset clears the queues, the engine state and the registers (fold 0, signed 1).
// The command queue decouples req from the engine; a full result queue stalls
// the engine on a last word only.
// ----------------------------------------------------------------------------
module file_name_hash #(
   parameter int CMD_DEPTH = 2,
   parameter int RSP_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   // input words
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_name_byte,
   input  logic        req_has_byte,
   input  logic        req_is_last,
   // results
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_hash_value,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   import fnh_pkg::*;

   localparam int CMD_W = $bits(cmd_type);

   cmd_type     front_cmd;   // classified word at the queue input
   cmd_type     back_cmd;    // oldest queued word
   logic        cmd_empty;
   logic        cmd_pop;
   logic        rsp_full;
   logic        rsp_push;
   logic [31:0] rsp_hash;

   // registers take a write every cycle
   assign csr_ready = 1'b1;

   fnh_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .name_byte (req_name_byte),
      .has_byte  (req_has_byte),
      .is_last   (req_is_last),
      .cmd       (front_cmd)
   );

   // command queue between front and engine
   fnh_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (front_cmd),
      .full  (req_full),
      .pop   (cmd_pop),
      .rdata (back_cmd),
      .empty (cmd_empty)
   );

   fnh_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd       (back_cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_hash  (rsp_hash)
   );

   // result queue, head drives the rsp ports
   fnh_fifo #(
      .WIDTH (32),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_hash),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .rdata (rsp_hash_value),
      .empty (rsp_empty)
   );

endmodule

@@ rtl/fnh_checker.sv @@
// ----------------------------------------------------------------------------
// fnh_checker
// Port-level checks of the file name hash block, bound to the top level.
// ----------------------------------------------------------------------------
`include "file_name_hash_assert.svh"

module fnh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_push,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [31:0] rsp_hash_value,
   input logic        csr_valid,
   input logic        csr_ready
);

   // reset leaves both queues empty
   `FNH_ASSERT_NEXT_ALWAYS(a_reset_clear, clock, reset, rsp_empty && !req_full)

   // only a pushed word can fill the input queue
   `FNH_ASSERT_NEXT(a_full_needs_push, clock, reset, !req_full && !req_push, !req_full)

   // a waiting result stays until popped
   `FNH_ASSERT_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop,
                    !rsp_empty && $stable(rsp_hash_value))

   // register writes never wait
   `FNH_ASSERT_NOW(a_csr_ready, clock, reset, csr_valid, csr_ready)

endmodule

bind file_name_hash fnh_checker u_fnh_checker (.*);
